// ===== src/tld_pkg.sv =====
`default_nettype none
package tld_pkg;

  localparam int LINE_DEPTH_DEF = 256;
  localparam int RING_DEPTH_DEF = 1024;

  localparam logic [2:0] OP_MASTER_WRITE = 3'd0;
  localparam logic [2:0] OP_MASTER_READ  = 3'd1;
  localparam logic [2:0] OP_SLAVE_WRITE  = 3'd2;
  localparam logic [2:0] OP_SLAVE_READ   = 3'd3;
  localparam logic [2:0] OP_DIRECT_INPUT = 3'd4;

  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_INTR  = 3'd1;
  localparam logic [2:0] CFG_QUIT  = 3'd2;
  localparam logic [2:0] CFG_SUSP  = 3'd3;
  localparam logic [2:0] CFG_EOF   = 3'd4;
  localparam logic [2:0] CFG_ERASE = 3'd5;
  localparam logic [2:0] CFG_KILL  = 3'd6;
  localparam logic [2:0] CFG_WERASE = 3'd7;

  localparam int MF_CR_TO_NL = 0;
  localparam int MF_SIGNALS  = 1;
  localparam int MF_CANON    = 2;
  localparam int MF_ECHO     = 3;
  localparam int MF_CARET    = 4;
  localparam int MF_ONLCR    = 5;

  localparam logic [1:0] SIG_NONE = 2'd0;
  localparam logic [1:0] SIG_INTR = 2'd1;
  localparam logic [1:0] SIG_QUIT = 2'd2;
  localparam logic [1:0] SIG_SUSP = 2'd3;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_Z     = 8'h5a;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
  } tld_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic       write_accepted;
    logic [1:0] signal_raised;
    logic       input_pending;
    logic       output_pending;
  } tld_out_t;

endpackage
`default_nettype wire

// ===== src/tld_ram.sv =====
`default_nettype none
module tld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/terminal_line_discipline.sv =====
`default_nettype none
// Channel  Ports                          Direction   Moves
// in       in_valid, in_stall, in_data    to block    one access (operation, data_byte)
// out      out_valid, out_stall, out_data from block  one result per access
// cfg      cfg_we, cfg_index, cfg_data    to block    one register write
//
// One transaction at a time: an access passes S_DECODE and S_DONE, a read adds S_RDWAIT and
// each echoed byte a pass through S_ECHO. Kill visits S_KILL per erased byte, plus S_ECHO
// with echo; word erase passes S_WREAD and S_WCHK per byte; a line flush alternates S_FLUSH
// and S_FLUSHW per stored byte for the registered line memory read, then adds the newline.
// rst_n is synchronous; pointers and line length clear, memories keep their contents.
// A new result waits in S_DONE while the previous one is still stalled.
module terminal_line_discipline
  import tld_pkg::*;
#(
  parameter int LINE_DEPTH = LINE_DEPTH_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire tld_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output tld_out_t      out_data,
  input  wire logic     cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int LW = $clog2(LINE_DEPTH);
  localparam int RW = $clog2(RING_DEPTH);
  localparam logic [LW-1:0] LINE_MAX = LW'(LINE_DEPTH - 1);
  localparam logic [RW-1:0] RING_LAST = RW'(RING_DEPTH - 1);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DECODE = 10'b0000000010,
    S_RDWAIT = 10'b0000000100,
    S_ECHO   = 10'b0000001000,
    S_KILL   = 10'b0000010000,
    S_WREAD  = 10'b0000100000,
    S_WCHK   = 10'b0001000000,
    S_FLUSH  = 10'b0010000000,
    S_FLUSHW = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0] op_r, op_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [LW-1:0] len_r, len_nxt, idx_r, idx_nxt;
  logic [RW-1:0] iwp_r, iwp_nxt, irp_r, irp_nxt, owp_r, owp_nxt, orp_r, orp_nxt;
  logic [2:0][7:0] ebuf_r, ebuf_nxt;
  logic [1:0] ecnt_r, ecnt_nxt;
  logic wphase_r, wphase_nxt;
  tld_out_t res_r, res_nxt, out_data_r, out_data_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [5:0] mode_r;
  logic [7:0] intr_r, quit_r, susp_r, eof_r, erase_r, kill_r, werase_r;

  logic i_we, o_we, l_we;
  logic [7:0] i_wd, l_rd, i_rd, o_rd;
  logic [LW-1:0] l_ra;
  logic [RW-1:0] iwp_inc, owp_inc, owp_inc2, irp_inc, orp_inc;
  logic i_room, o_room, o_room2;
  logic [7:0] c;
  logic echo;

  tld_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_line (
    .clk(clk), .we(l_we), .waddr(len_r), .wdata(c), .raddr(l_ra), .rdata(l_rd)
  );
  tld_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_inq (
    .clk(clk), .we(i_we), .waddr(iwp_r), .wdata(i_wd), .raddr(irp_r), .rdata(i_rd)
  );
  tld_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_outq (
    .clk(clk), .we(o_we), .waddr(owp_r), .wdata(ebuf_r[0]), .raddr(orp_r), .rdata(o_rd)
  );

  assign iwp_inc  = (iwp_r == RING_LAST) ? '0 : iwp_r + RW'(1);
  assign owp_inc  = (owp_r == RING_LAST) ? '0 : owp_r + RW'(1);
  assign owp_inc2 = (owp_inc == RING_LAST) ? '0 : owp_inc + RW'(1);
  assign irp_inc  = (irp_r == RING_LAST) ? '0 : irp_r + RW'(1);
  assign orp_inc  = (orp_r == RING_LAST) ? '0 : orp_r + RW'(1);
  assign i_room   = (iwp_inc != irp_r);
  assign o_room   = (owp_inc != orp_r);
  assign o_room2  = o_room && (owp_inc2 != orp_r);
  assign c = (mode_r[MF_CR_TO_NL] && byte_r == CH_CR) ? CH_NL : byte_r;
  assign echo = mode_r[MF_ECHO];
  assign l_ra = (state_r == S_WREAD) ? len_r - LW'(1) : idx_r;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_comb begin
    state_nxt = state_r;
    ret_nxt = ret_r;
    op_nxt = op_r;
    byte_nxt = byte_r;
    len_nxt = len_r;
    idx_nxt = idx_r;
    iwp_nxt = iwp_r;
    irp_nxt = irp_r;
    owp_nxt = owp_r;
    orp_nxt = orp_r;
    ebuf_nxt = ebuf_r;
    ecnt_nxt = ecnt_r;
    wphase_nxt = wphase_r;
    res_nxt = res_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    i_we = 1'b0;
    i_wd = c;
    o_we = 1'b0;
    l_we = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt = in_data.operation;
          byte_nxt = in_data.data_byte;
          res_nxt = '0;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        ret_nxt = S_DONE;
        case (op_r)
          OP_MASTER_WRITE: begin
            res_nxt.write_accepted = 1'b1;
            if (mode_r[MF_SIGNALS] && (c == intr_r || c == quit_r || c == susp_r)) begin
              len_nxt = '0;
              ebuf_nxt = {CH_NL, CH_C, CH_CARET};
              res_nxt.signal_raised = SIG_INTR;
              if (c != intr_r && c == quit_r) begin
                ebuf_nxt = {CH_NL, CH_BSL, CH_CARET};
                res_nxt.signal_raised = SIG_QUIT;
              end else if (c != intr_r) begin
                ebuf_nxt = {CH_NL, CH_Z, CH_CARET};
                res_nxt.signal_raised = SIG_SUSP;
              end
              ecnt_nxt = 2'd3;
              if (echo) state_nxt = S_ECHO;
            end else if (!mode_r[MF_CANON]) begin
              if (i_room) begin
                i_we = 1'b1;
                iwp_nxt = iwp_inc;
              end
              ebuf_nxt = {8'h00, 8'h00, c};
              ecnt_nxt = 2'd1;
              if (mode_r[MF_ONLCR] && c == CH_NL) begin
                ebuf_nxt = {8'h00, CH_NL, CH_CR};
                ecnt_nxt = 2'd2;
              end
              if (echo) state_nxt = S_ECHO;
            end else if (c == eof_r) begin
              if (len_r != '0) begin
                idx_nxt = '0;
                state_nxt = S_FLUSH;
              end
            end else if (c == CH_BS || c == erase_r) begin
              if (len_r != '0) begin
                len_nxt = len_r - LW'(1);
                ebuf_nxt = {CH_BS, CH_SP, CH_BS};
                ecnt_nxt = 2'd3;
                if (echo) state_nxt = S_ECHO;
              end
            end else if (c == kill_r) begin
              state_nxt = S_KILL;
            end else if (c == werase_r && werase_r != 8'h00) begin
              wphase_nxt = 1'b0;
              state_nxt = S_WREAD;
            end else if (c == CH_NL) begin
              idx_nxt = '0;
              ebuf_nxt = {8'h00, 8'h00, CH_NL};
              ecnt_nxt = 2'd1;
              if (mode_r[MF_ONLCR]) begin
                ebuf_nxt = {8'h00, CH_NL, CH_CR};
                ecnt_nxt = 2'd2;
              end
              ret_nxt = S_FLUSH;
              state_nxt = echo ? S_ECHO : S_FLUSH;
            end else if (len_r < LINE_MAX) begin
              l_we = 1'b1;
              len_nxt = len_r + LW'(1);
              ebuf_nxt = {8'h00, 8'h00, c};
              ecnt_nxt = 2'd1;
              if (mode_r[MF_CARET] && c[7:5] == 3'b000 && c != CH_TAB) begin
                ebuf_nxt = {8'h00, c + CH_AT, CH_CARET};
                ecnt_nxt = 2'd2;
              end else if (mode_r[MF_ONLCR] && c == CH_NL) begin
                ebuf_nxt = {8'h00, CH_NL, CH_CR};
                ecnt_nxt = 2'd2;
              end
              if (echo) state_nxt = S_ECHO;
            end
          end
          OP_MASTER_READ: begin
            if (orp_r != owp_r) state_nxt = S_RDWAIT;
          end
          OP_SLAVE_READ: begin
            if (irp_r != iwp_r) state_nxt = S_RDWAIT;
          end
          OP_SLAVE_WRITE: begin
            if (mode_r[MF_ONLCR] && byte_r == CH_NL) begin
              ebuf_nxt = {8'h00, CH_NL, CH_CR};
              ecnt_nxt = 2'd2;
              if (o_room2) begin
                res_nxt.write_accepted = 1'b1;
                state_nxt = S_ECHO;
              end
            end else begin
              ebuf_nxt = {8'h00, 8'h00, byte_r};
              ecnt_nxt = 2'd1;
              if (o_room) begin
                res_nxt.write_accepted = 1'b1;
                state_nxt = S_ECHO;
              end
            end
          end
          OP_DIRECT_INPUT: begin
            i_wd = byte_r;
            if (i_room) begin
              i_we = 1'b1;
              iwp_nxt = iwp_inc;
              res_nxt.write_accepted = 1'b1;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RDWAIT: begin
        res_nxt.read_valid = 1'b1;
        if (op_r == OP_MASTER_READ) begin
          res_nxt.read_byte = o_rd;
          orp_nxt = orp_inc;
        end else begin
          res_nxt.read_byte = i_rd;
          irp_nxt = irp_inc;
        end
        state_nxt = S_DONE;
      end
      S_ECHO: begin
        if (o_room) begin
          o_we = 1'b1;
          owp_nxt = owp_inc;
        end
        ebuf_nxt = {8'h00, ebuf_r[2], ebuf_r[1]};
        ecnt_nxt = ecnt_r - 2'd1;
        if (ecnt_r == 2'd1) state_nxt = ret_r;
      end
      S_KILL: begin
        if (len_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          len_nxt = len_r - LW'(1);
          ebuf_nxt = {CH_BS, CH_SP, CH_BS};
          ecnt_nxt = 2'd3;
          ret_nxt = S_KILL;
          if (echo) state_nxt = S_ECHO;
        end
      end
      S_WREAD: begin
        state_nxt = (len_r == '0) ? S_DONE : S_WCHK;
      end
      S_WCHK: begin
        if (wphase_r ? (l_rd != CH_SP) : (l_rd == CH_SP)) begin
          len_nxt = len_r - LW'(1);
          ebuf_nxt = {CH_BS, CH_SP, CH_BS};
          ecnt_nxt = 2'd3;
          ret_nxt = S_WREAD;
          state_nxt = echo ? S_ECHO : S_WREAD;
        end else if (!wphase_r) begin
          wphase_nxt = 1'b1;
          state_nxt = S_WREAD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FLUSH: begin
        if (idx_r < len_r) begin
          state_nxt = S_FLUSHW;
        end else begin
          i_wd = CH_NL;
          if (i_room) begin
            i_we = 1'b1;
            iwp_nxt = iwp_inc;
          end
          len_nxt = '0;
          state_nxt = S_DONE;
        end
      end
      S_FLUSHW: begin
        i_wd = l_rd;
        if (i_room) begin
          i_we = 1'b1;
          iwp_nxt = iwp_inc;
        end
        idx_nxt = idx_r + LW'(1);
        state_nxt = S_FLUSH;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt = res_r;
          out_data_nxt.input_pending = (irp_r != iwp_r);
          out_data_nxt.output_pending = (orp_r != owp_r);
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_DONE;
      len_r <= '0;
      iwp_r <= '0;
      irp_r <= '0;
      owp_r <= '0;
      orp_r <= '0;
      out_valid_r <= 1'b0;
      mode_r <= 6'h3f;
      intr_r <= 8'd3;
      quit_r <= 8'd28;
      susp_r <= 8'd26;
      eof_r <= 8'd4;
      erase_r <= 8'd127;
      kill_r <= 8'd21;
      werase_r <= 8'd23;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      len_r <= len_nxt;
      iwp_r <= iwp_nxt;
      irp_r <= irp_nxt;
      owp_r <= owp_nxt;
      orp_r <= orp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODE:   mode_r <= cfg_data[5:0];
          CFG_INTR:   intr_r <= cfg_data;
          CFG_QUIT:   quit_r <= cfg_data;
          CFG_SUSP:   susp_r <= cfg_data;
          CFG_EOF:    eof_r <= cfg_data;
          CFG_ERASE:  erase_r <= cfg_data;
          CFG_KILL:   kill_r <= cfg_data;
          CFG_WERASE: werase_r <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
    byte_r <= byte_nxt;
    idx_r <= idx_nxt;
    ebuf_r <= ebuf_nxt;
    ecnt_r <= ecnt_nxt;
    wphase_r <= wphase_nxt;
    res_r <= res_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LINE_MAX) else $error("line length beyond buffer");
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_DECODE) else $error("accepted item not decoded");
  a_echo_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ECHO |-> ecnt_r != 2'd0) else $error("echo with empty buffer");
  a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
    iwp_r <= RING_LAST && owp_r <= RING_LAST) else $error("ring pointer out of range");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && !out_stall |=> out_valid_r) else $error("result not presented");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/terminal_line_discipline_tb.sv =====
`default_nettype none
module terminal_line_discipline_tb;
  import tld_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LDEPTH = 256;
  localparam int RDEPTH = 1024;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tld_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tld_out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  terminal_line_discipline u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tld_in_t access_q[$];
  tld_out_t want_q[$];
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  logic quiet = 1'b0;
  logic hold_go = 1'b0;
  int hold_cnt = 0;
  wire long_hold = hold_go && hold_cnt < 600;
  int in_gap = 0;
  int out_gap = 0;

  // terminal state mirror
  logic [7:0] creg[8];
  logic [7:0] line_mem[LDEPTH];
  int line_len;
  logic [7:0] in_ring[RDEPTH];
  logic [7:0] out_ring[RDEPTH];
  int in_rd, in_wr, out_rd, out_wr;

  function automatic int ring_fill(int rd, int wr);
    return (wr - rd + RDEPTH) % RDEPTH;
  endfunction

  function automatic void put_in(logic [7:0] b);
    if (RDEPTH - 1 - ring_fill(in_rd, in_wr) > 0) begin
      in_ring[in_wr] = b;
      in_wr = (in_wr + 1) % RDEPTH;
    end
  endfunction

  function automatic void put_out(logic [7:0] b);
    if (RDEPTH - 1 - ring_fill(out_rd, out_wr) > 0) begin
      out_ring[out_wr] = b;
      out_wr = (out_wr + 1) % RDEPTH;
    end
  endfunction

  function automatic void put_cooked(logic [7:0] b);
    if (creg[CFG_MODE][MF_ONLCR] && b == CH_NL) begin
      put_out(CH_CR);
      put_out(CH_NL);
    end else begin
      put_out(b);
    end
  endfunction

  function automatic void rub_one();
    line_len--;
    if (creg[CFG_MODE][MF_ECHO]) begin
      put_out(CH_BS);
      put_out(CH_SP);
      put_out(CH_BS);
    end
  endfunction

  function automatic void flush_line();
    for (int i = 0; i < line_len; i++) put_in(line_mem[i]);
    put_in(CH_NL);
    line_len = 0;
  endfunction

  function automatic void echo_signal(logic [7:0] letter);
    if (creg[CFG_MODE][MF_ECHO]) begin
      put_out(CH_CARET);
      put_out(letter);
      put_out(CH_NL);
    end
    line_len = 0;
  endfunction

  function automatic logic [1:0] keyboard_byte(logic [7:0] c);
    logic echo;
    echo = creg[CFG_MODE][MF_ECHO];
    if (creg[CFG_MODE][MF_CR_TO_NL] && c == CH_CR) c = CH_NL;
    if (creg[CFG_MODE][MF_SIGNALS]) begin
      if (c == creg[CFG_INTR]) begin
        echo_signal(CH_C);
        return SIG_INTR;
      end
      if (c == creg[CFG_QUIT]) begin
        echo_signal(CH_BSL);
        return SIG_QUIT;
      end
      if (c == creg[CFG_SUSP]) begin
        echo_signal(CH_Z);
        return SIG_SUSP;
      end
    end
    if (!creg[CFG_MODE][MF_CANON]) begin
      put_in(c);
      if (echo) put_cooked(c);
      return SIG_NONE;
    end
    if (c == creg[CFG_EOF]) begin
      if (line_len > 0) flush_line();
    end else if (c == CH_BS || c == creg[CFG_ERASE]) begin
      if (line_len > 0) rub_one();
    end else if (c == creg[CFG_KILL]) begin
      while (line_len > 0) rub_one();
    end else if (c == creg[CFG_WERASE] && creg[CFG_WERASE] != 8'd0) begin
      while (line_len > 0 && line_mem[line_len - 1] == CH_SP) rub_one();
      while (line_len > 0 && line_mem[line_len - 1] != CH_SP) rub_one();
    end else if (c == CH_NL) begin
      if (echo) put_cooked(CH_NL);
      flush_line();
    end else if (line_len < LDEPTH - 1) begin
      line_mem[line_len] = c;
      line_len++;
      if (echo) begin
        if (creg[CFG_MODE][MF_CARET] && c < 8'd32 && c != CH_TAB) begin
          put_out(CH_CARET);
          put_out(c + CH_AT);
        end else begin
          put_cooked(c);
        end
      end
    end
    return SIG_NONE;
  endfunction

  function automatic tld_out_t tty_predict(tld_in_t x);
    tld_out_t r;
    r = '0;
    case (x.operation)
      OP_MASTER_WRITE: begin
        r.signal_raised = keyboard_byte(x.data_byte);
        r.write_accepted = 1'b1;
      end
      OP_MASTER_READ: begin
        if (ring_fill(out_rd, out_wr) > 0) begin
          r.read_byte = out_ring[out_rd];
          r.read_valid = 1'b1;
          out_rd = (out_rd + 1) % RDEPTH;
        end
      end
      OP_SLAVE_WRITE: begin
        if (creg[CFG_MODE][MF_ONLCR] && x.data_byte == CH_NL) begin
          if (RDEPTH - 1 - ring_fill(out_rd, out_wr) >= 2) begin
            put_out(CH_CR);
            put_out(CH_NL);
            r.write_accepted = 1'b1;
          end
        end else if (RDEPTH - 1 - ring_fill(out_rd, out_wr) > 0) begin
          put_out(x.data_byte);
          r.write_accepted = 1'b1;
        end
      end
      OP_SLAVE_READ: begin
        if (ring_fill(in_rd, in_wr) > 0) begin
          r.read_byte = in_ring[in_rd];
          r.read_valid = 1'b1;
          in_rd = (in_rd + 1) % RDEPTH;
        end
      end
      OP_DIRECT_INPUT: begin
        if (RDEPTH - 1 - ring_fill(in_rd, in_wr) > 0) begin
          put_in(x.data_byte);
          r.write_accepted = 1'b1;
        end
      end
      default: ;
    endcase
    r.input_pending = ring_fill(in_rd, in_wr) > 0;
    r.output_pending = ring_fill(out_rd, out_wr) > 0;
    return r;
  endfunction

  task automatic report(string field, int want, int got);
    errors++;
    $display("mismatch on result %0d: %s expected %0d got %0d", checked, field, want, got);
  endtask

  // driver
  always @(posedge clk) begin
    logic sent;
    sent = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      in_gap <= 0;
    end else begin
      if (sent) begin
        want_q.push_back(tty_predict(in_data));
        void'(access_q.pop_front());
      end
      if (in_valid && !sent) begin
        // hold
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        in_gap <= $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (access_q.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= access_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= long_hold;
    end
  end

  always @(posedge clk) begin
    if (hold_go && hold_cnt < 600) hold_cnt <= hold_cnt + 1;
  end

  // monitor
  always @(posedge clk) begin
    tld_out_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        report("unexpected transaction", 0, 1);
      end else begin
        w = want_q.pop_front();
        if (w.read_byte !== out_data.read_byte)
          report("read_byte", w.read_byte, out_data.read_byte);
        if (w.read_valid !== out_data.read_valid)
          report("read_valid", w.read_valid, out_data.read_valid);
        if (w.write_accepted !== out_data.write_accepted)
          report("write_accepted", w.write_accepted, out_data.write_accepted);
        if (w.signal_raised !== out_data.signal_raised)
          report("signal_raised", w.signal_raised, out_data.signal_raised);
        if (w.input_pending !== out_data.input_pending)
          report("input_pending", w.input_pending, out_data.input_pending);
        if (w.output_pending !== out_data.output_pending)
          report("output_pending", w.output_pending, out_data.output_pending);
      end
      checked++;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add(logic [2:0] op, logic [7:0] b);
    tld_in_t x;
    x.operation = op;
    x.data_byte = b;
    access_q.push_back(x);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    creg[idx] = v;
  endtask

  task automatic set_regs(logic [7:0] m, logic [7:0] i, logic [7:0] q, logic [7:0] s,
                          logic [7:0] e, logic [7:0] er, logic [7:0] k, logic [7:0] w);
    write_reg(CFG_MODE, m);
    write_reg(CFG_INTR, i);
    write_reg(CFG_QUIT, q);
    write_reg(CFG_SUSP, s);
    write_reg(CFG_EOF, e);
    write_reg(CFG_ERASE, er);
    write_reg(CFG_KILL, k);
    write_reg(CFG_WERASE, w);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (access_q.size() != 0 || want_q.size() != 0 || in_valid);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
      3: return CH_SP;
      4: return creg[3'($urandom_range(1, 7))];
      5: begin
        case ($urandom_range(0, 3))
          0: return CH_CR;
          1: return CH_NL;
          2: return CH_BS;
          default: return CH_TAB;
        endcase
      end
      6: return 8'($urandom_range(0, 31));
      7: return 8'($urandom_range(0, 255));
      default: return 8'h30 + 8'($urandom_range(0, 9));
    endcase
  endfunction

  task automatic gen_random(int n);
    int made, len;
    made = 0;
    while (made < n) begin
      len = $urandom_range(0, 12);
      repeat (len) add(OP_MASTER_WRITE, pick_byte());
      case ($urandom_range(0, 4))
        0: add(OP_MASTER_WRITE, CH_CR);
        1: add(OP_MASTER_WRITE, creg[CFG_EOF]);
        2: add(OP_MASTER_WRITE, creg[3'($urandom_range(1, 3))]);
        default: add(OP_MASTER_WRITE, CH_NL);
      endcase
      made += len + 1;
      repeat ($urandom_range(2, 16)) begin
        add(OP_MASTER_READ, 8'($urandom_range(0, 255)));
        made++;
      end
      repeat ($urandom_range(2, 14)) begin
        add(OP_SLAVE_READ, 8'($urandom_range(0, 255)));
        made++;
      end
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 5))
          0, 1: add(OP_SLAVE_WRITE, pick_byte());
          2: add(OP_SLAVE_WRITE, CH_NL);
          3: add(OP_DIRECT_INPUT, 8'($urandom_range(0, 255)));
          default: add(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)));
        endcase
        made++;
      end
    end
  endtask

  initial begin
    creg[CFG_MODE] = 8'd63;
    creg[CFG_INTR] = 8'd3;
    creg[CFG_QUIT] = 8'd28;
    creg[CFG_SUSP] = 8'd26;
    creg[CFG_EOF] = 8'd4;
    creg[CFG_ERASE] = 8'd127;
    creg[CFG_KILL] = 8'd21;
    creg[CFG_WERASE] = 8'd23;
    line_len = 0;
    in_rd = 0;
    in_wr = 0;
    out_rd = 0;
    out_wr = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_regs(8'd63, 8'd3, 8'd28, 8'd26, 8'd4, 8'd127, 8'd21, 8'd23);
    add(OP_MASTER_WRITE, 8'h61);
    add(OP_MASTER_WRITE, 8'h62);
    add(OP_MASTER_WRITE, CH_TAB);
    add(OP_MASTER_WRITE, 8'h01);
    add(OP_MASTER_WRITE, 8'd127);
    add(OP_MASTER_WRITE, CH_BS);
    add(OP_MASTER_WRITE, CH_SP);
    add(OP_MASTER_WRITE, 8'h63);
    add(OP_MASTER_WRITE, 8'd23);
    add(OP_MASTER_WRITE, 8'd21);
    add(OP_MASTER_WRITE, 8'd4);
    add(OP_MASTER_WRITE, 8'hff);
    add(OP_MASTER_WRITE, 8'd4);
    add(OP_MASTER_WRITE, CH_CR);
    add(OP_MASTER_WRITE, 8'd3);
    add(OP_MASTER_WRITE, 8'd28);
    add(OP_MASTER_WRITE, 8'd26);
    add(OP_SLAVE_WRITE, CH_NL);
    add(OP_SLAVE_WRITE, 8'hff);
    add(OP_DIRECT_INPUT, 8'h00);
    add(3'd5, 8'h00);
    add(3'd6, 8'h55);
    add(3'd7, 8'hff);
    add(OP_MASTER_READ, 8'h00);
    add(OP_SLAVE_READ, 8'hff);
    drain();

    gen_random(320);
    repeat (200) @(posedge clk);
    hold_go <= 1'b1;
    drain();

    set_regs(8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255);
    gen_random(120);
    drain();

    repeat (2) begin
      set_regs(8'($urandom_range(0, 63)), 8'($urandom_range(0, 31)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 31)),
               8'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)));
      gen_random(100);
      drain();
    end

    quiet <= 1'b1;
    set_regs(8'd63, 8'd3, 8'd28, 8'd26, 8'd4, 8'd127, 8'd21, 8'd23);
    gen_random(100);
    drain();

    // full line buffer, long kill walk, then the output ring filled past capacity
    set_regs(8'd63, 8'd3, 8'd28, 8'd26, 8'd4, 8'd127, 8'd21, 8'd0);
    repeat (260) add(OP_MASTER_WRITE, 8'h71);
    add(OP_MASTER_WRITE, 8'h20);
    add(OP_MASTER_WRITE, 8'd23);
    add(OP_MASTER_WRITE, 8'd21);
    add(OP_MASTER_WRITE, 8'd3);
    add(OP_MASTER_WRITE, 8'd28);
    add(OP_MASTER_WRITE, 8'd26);
    add(OP_SLAVE_WRITE, CH_NL);
    add(OP_SLAVE_WRITE, 8'h7a);
    add(OP_DIRECT_INPUT, 8'h41);
    repeat (6) add(OP_MASTER_READ, 8'h00);
    add(OP_SLAVE_WRITE, CH_NL);
    add(OP_SLAVE_WRITE, 8'h7a);
    repeat (6) add(OP_SLAVE_READ, 8'h00);
    drain();
    repeat (50) @(posedge clk);

    $display("covered canonical editing, signals, raw mode, echo forms and a full output ring");
    $display("%0d results checked over %0d cycles", checked, cycles);
    if (errors == 0 && want_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
